FILE: hdl/tfn_pkg.sv
// shared types and constants for the triangle face normal engine
`default_nettype none
package tfn_pkg;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned SLOT_W = 12;
	localparam int unsigned NORM_W = 16;
	localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_FACE = 1'b1
	} mode_t;

	typedef struct packed {
		logic mode;
		logic [SLOT_W-1:0] vertex_slot;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [SLOT_W-1:0] corner_one;
		logic [SLOT_W-1:0] corner_two;
		logic [SLOT_W-1:0] corner_three;
	} in_beat_t;

	typedef struct packed {
		logic result_kind;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic degenerate;
		logic [COORD_W-1:0] extent_x;
		logic [COORD_W-1:0] extent_y;
		logic [COORD_W-1:0] extent_z;
	} out_beat_t;

	// command handed from the front part to the back part
	typedef struct packed {
		logic face;
		logic [COORD_W-1:0] ext_x;
		logic [COORD_W-1:0] ext_y;
		logic [COORD_W-1:0] ext_z;
		logic signed [COORD_W:0] e1x;
		logic signed [COORD_W:0] e1y;
		logic signed [COORD_W:0] e1z;
		logic signed [COORD_W:0] e2x;
		logic signed [COORD_W:0] e2y;
		logic signed [COORD_W:0] e2z;
	} cmd_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_RD1,
		FS_RD2,
		FS_RD3,
		FS_PUSH
	} fstate_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_MUL,
		BS_CROSS,
		BS_NORM,
		BS_SQRT,
		BS_DIV,
		BS_OUT
	} bstate_t;

endpackage
`default_nettype wire

FILE: hdl/triangle_face_normal_engine.sv
// top level of the triangle face normal engine
// channels: in (valid/stall, in_beat) carries vertex loads and face requests;
// out (valid/stall, out_beat) returns one beat per input beat, in order
// a load writes one vertex and updates the per-axis extents; it is
// acknowledged with a zero normal and the extents after the load
// a face reads its three corners from the vertex table, forms the edges,
// takes the cross product, scales it and divides by its length
// the back part runs a 32-step square root and three 45-step divides one
// after another for a face that is not flat and pops a new command only
// once its beat is out; the front part takes a beat only once the last is queued
// the front part feeds a two-entry queue so it keeps reading corners while
// the back part divides
// reset clears the extents, queue and all control; the table is not cleared
// a stalled output beat holds; the queue fills and then the input stalls
`default_nettype none
module triangle_face_normal_engine #(
	parameter int unsigned VERTEX_DEPTH = 4096,
	parameter int unsigned COORD_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tfn_pkg::in_beat_t in_beat,
	output logic out_valid,
	input wire logic out_stall,
	output tfn_pkg::out_beat_t out_beat
);
	tfn_pkg::cmd_t f_cmd, q_cmd;
	logic f_valid, q_full, q_empty, q_pop;

	tfn_front #(.VERTEX_DEPTH(VERTEX_DEPTH), .COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_beat(in_beat), .cmd_valid(f_valid), .cmd_full(q_full), .cmd(f_cmd)
	);

	tfn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_data(f_cmd), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_cmd)
	);

	tfn_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
	);
endmodule
`default_nettype wire

FILE: hdl/tfn_front.sv
// front part: vertex table, extents, corner fetch and edge forming
`default_nettype none
module tfn_front #(
	parameter int unsigned VERTEX_DEPTH = 4096,
	parameter int unsigned COORD_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tfn_pkg::in_beat_t in_beat,
	output logic cmd_valid,
	input wire logic cmd_full,
	output tfn_pkg::cmd_t cmd
);
	localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int unsigned CW = tfn_pkg::COORD_W;
	localparam int unsigned VW = 3 * COORD_BITS;

	logic [VW-1:0] mem [VERTEX_DEPTH];
	logic [VW-1:0] rd_q;
	tfn_pkg::fstate_t state_q, state_d;
	tfn_pkg::in_beat_t beat_q;
	logic inb_q [3];
	logic signed [CW-1:0] a_q [3];
	logic signed [CW-1:0] b_q [3];
	logic [CW-1:0] ext_q [3];
	logic [CW-1:0] sx, sy, sz;
	logic [CW-1:0] ax, ay, az;
	logic load_ok;
	logic [AW-1:0] rd_addr;
	logic rd_ok;
	logic signed [CW-1:0] vrd [3];

	function automatic logic [CW-1:0] sext(input logic [CW-1:0] r);
		logic [CW-1:0] v;
		v = '0;
		v[COORD_BITS-1:0] = r[COORD_BITS-1:0];
		for (int k = COORD_BITS; k < CW; k++) v[k] = r[COORD_BITS-1];
		return v;
	endfunction

	function automatic logic [CW-1:0] absv(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + 1'b1) : v;
	endfunction

	assign sx = sext(beat_q.coord_x);
	assign sy = sext(beat_q.coord_y);
	assign sz = sext(beat_q.coord_z);
	assign ax = absv(sx);
	assign ay = absv(sy);
	assign az = absv(sz);
	assign load_ok = 32'(beat_q.vertex_slot) < VERTEX_DEPTH;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vrd[k] = CW'($signed(rd_q[k*COORD_BITS +: COORD_BITS]));
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		rd_ok = 1'b0;
		in_stall = 1'b1;
		cmd_valid = 1'b0;
		case (state_q)
			tfn_pkg::FS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = tfn_pkg::FS_RD1;
			end
			tfn_pkg::FS_RD1: begin
				rd_addr = AW'(beat_q.corner_one);
				rd_ok = 1'b1;
				state_d = (beat_q.mode == tfn_pkg::MODE_FACE) ? tfn_pkg::FS_RD2
					: tfn_pkg::FS_PUSH;
			end
			tfn_pkg::FS_RD2: begin
				rd_addr = AW'(beat_q.corner_two);
				rd_ok = 1'b1;
				state_d = tfn_pkg::FS_RD3;
			end
			tfn_pkg::FS_RD3: begin
				rd_addr = AW'(beat_q.corner_three);
				rd_ok = 1'b1;
				state_d = tfn_pkg::FS_PUSH;
			end
			tfn_pkg::FS_PUSH: begin
				cmd_valid = 1'b1;
				if (!cmd_full) state_d = tfn_pkg::FS_IDLE;
			end
			default: state_d = tfn_pkg::FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfn_pkg::FS_IDLE;
			for (int k = 0; k < 3; k++) ext_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tfn_pkg::FS_RD1 && beat_q.mode == tfn_pkg::MODE_LOAD
				&& load_ok) begin
				if (ax > ext_q[0]) ext_q[0] <= ax;
				if (ay > ext_q[1]) ext_q[1] <= ay;
				if (az > ext_q[2]) ext_q[2] <= az;
			end
		end
	end

	// vertex table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (state_q == tfn_pkg::FS_RD1 && beat_q.mode == tfn_pkg::MODE_LOAD && load_ok)
			mem[AW'(beat_q.vertex_slot)] <= {sz[COORD_BITS-1:0], sy[COORD_BITS-1:0],
				sx[COORD_BITS-1:0]};
		if (rd_ok) rd_q <= mem[rd_addr];
	end

	// corner in range flags are registered together with each table read, so each flag lines up with its read data
	always_ff @(posedge clk) begin
		if (state_q == tfn_pkg::FS_IDLE && in_valid) beat_q <= in_beat;
		if (state_q == tfn_pkg::FS_RD1) inb_q[0] <= 32'(beat_q.corner_one) < VERTEX_DEPTH;
		if (state_q == tfn_pkg::FS_RD2) begin
			inb_q[1] <= 32'(beat_q.corner_two) < VERTEX_DEPTH;
			for (int k = 0; k < 3; k++) a_q[k] <= inb_q[0] ? vrd[k] : '0;
		end
		if (state_q == tfn_pkg::FS_RD3) begin
			inb_q[2] <= 32'(beat_q.corner_three) < VERTEX_DEPTH;
			for (int k = 0; k < 3; k++) b_q[k] <= inb_q[1] ? vrd[k] : '0;
		end
	end

	always_comb begin
		logic signed [CW-1:0] c [3];
		for (int k = 0; k < 3; k++) c[k] = inb_q[2] ? vrd[k] : '0;
		cmd.face = beat_q.mode;
		cmd.ext_x = ext_q[0];
		cmd.ext_y = ext_q[1];
		cmd.ext_z = ext_q[2];
		cmd.e1x = (CW+1)'(a_q[0]) - (CW+1)'(b_q[0]);
		cmd.e1y = (CW+1)'(a_q[1]) - (CW+1)'(b_q[1]);
		cmd.e1z = (CW+1)'(a_q[2]) - (CW+1)'(b_q[2]);
		cmd.e2x = (CW+1)'(a_q[0]) - (CW+1)'(c[0]);
		cmd.e2y = (CW+1)'(a_q[1]) - (CW+1)'(c[1]);
		cmd.e2z = (CW+1)'(a_q[2]) - (CW+1)'(c[2]);
	end
endmodule
`default_nettype wire

FILE: hdl/tfn_queue.sv
// short queue between front and back parts
`default_nettype none
module tfn_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire tfn_pkg::cmd_t push_data,
	output logic full,
	input wire logic pop,
	output logic empty,
	output tfn_pkg::cmd_t pop_data
);
	tfn_pkg::cmd_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

FILE: hdl/tfn_back.sv
// back part: cross product, normalize, square root and divide
`default_nettype none
module tfn_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_empty,
	input wire tfn_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input wire logic out_stall,
	output tfn_pkg::out_beat_t out_beat
);
	localparam int unsigned CW = tfn_pkg::COORD_W;
	localparam int unsigned NW = tfn_pkg::NORM_W;

	tfn_pkg::bstate_t state_q, state_d;
	tfn_pkg::cmd_t cmd_q;
	logic signed [2*CW+1:0] prod_q [6];
	logic [64:0] mag_q [3];
	logic neg_q [3];
	logic [29:0] nm_q [3];
	logic [63:0] s_q, rem_q;
	logic [31:0] root_q;
	logic [5:0] cnt_q;
	logic [1:0] comp_q;
	logic [44:0] num_q;
	logic [31:0] quo_q;
	logic [45:0] drem_q;
	logic [NW-1:0] res_q [3];
	logic degen_q;
	tfn_pkg::out_beat_t obuf_q;
	logic ovalid_q;

	// one step of the restoring square root, two radicand bits per step
	logic [65:0] sq_trial;
	logic [65:0] sq_rem;
	assign sq_rem = {rem_q, s_q[63:62]};
	assign sq_trial = sq_rem - {32'd0, root_q, 2'b01};

	// one step of the restoring divide, one quotient bit per step
	logic [46:0] dv_trial;
	logic [31:0] quo_nx;
	assign dv_trial = {drem_q, num_q[44]} - {15'd0, root_q};
	assign quo_nx = {quo_q[30:0], ~dv_trial[46]};

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			tfn_pkg::BS_IDLE: if (!cmd_empty) begin
				cmd_pop = 1'b1;
				state_d = tfn_pkg::BS_MUL;
			end
			tfn_pkg::BS_MUL: state_d = cmd_q.face ? tfn_pkg::BS_CROSS : tfn_pkg::BS_OUT;
			tfn_pkg::BS_CROSS: state_d = tfn_pkg::BS_NORM;
			tfn_pkg::BS_NORM: state_d = tfn_pkg::BS_SQRT;
			tfn_pkg::BS_SQRT: if (degen_q) state_d = tfn_pkg::BS_OUT;
				else if (cnt_q == 6'd32) state_d = tfn_pkg::BS_DIV;
			tfn_pkg::BS_DIV: if (cnt_q == 6'd44 && comp_q == 2'd2) state_d = tfn_pkg::BS_OUT;
			tfn_pkg::BS_OUT: if (!ovalid_q || !out_stall) state_d = tfn_pkg::BS_IDLE;
			default: state_d = tfn_pkg::BS_IDLE;
		endcase
	end

	function automatic logic [6:0] blen(input logic [64:0] v);
		logic [6:0] r;
		r = '0;
		for (int k = 0; k < 65; k++) if (v[k]) r = 7'(k + 1);
		return r;
	endfunction

	logic [64:0] mmax;
	logic [6:0] bl;
	always_comb begin
		mmax = mag_q[0];
		if (mag_q[1] > mmax) mmax = mag_q[1];
		if (mag_q[2] > mmax) mmax = mag_q[2];
		bl = blen(mmax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfn_pkg::BS_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tfn_pkg::BS_OUT && (!ovalid_q || !out_stall)) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [2*CW+2:0] d;
		logic [64:0] mg [3];
		logic any;
		logic [5:0] sh;
		logic [59:0] sq;
		case (state_q)
			tfn_pkg::BS_IDLE: begin
				cmd_q <= cmd;
			end
			tfn_pkg::BS_MUL: begin
				prod_q[0] <= cmd_q.e1y * cmd_q.e2z;
				prod_q[1] <= cmd_q.e1z * cmd_q.e2y;
				prod_q[2] <= cmd_q.e1z * cmd_q.e2x;
				prod_q[3] <= cmd_q.e1x * cmd_q.e2z;
				prod_q[4] <= cmd_q.e1x * cmd_q.e2y;
				prod_q[5] <= cmd_q.e1y * cmd_q.e2x;
				degen_q <= 1'b0;
				for (int k = 0; k < 3; k++) res_q[k] <= '0;
			end
			tfn_pkg::BS_CROSS: begin
				for (int k = 0; k < 3; k++) begin
					d = (2*CW+3)'(prod_q[2*k]) - (2*CW+3)'(prod_q[2*k+1]);
					neg_q[k] <= d[2*CW+2];
					mag_q[k] <= 65'(d[2*CW+2] ? -d : d);
				end
			end
			tfn_pkg::BS_NORM: begin
				any = mmax[64];
				for (int k = 0; k < 3; k++) mg[k] = any ? (mag_q[k] >> 1) : mag_q[k];
				sh = any ? 6'(bl - 7'd1) : 6'(bl);
				s_q <= '0;
				sq = '0;
				for (int k = 0; k < 3; k++) begin
					if (sh > 6'd30) nm_q[k] <= 30'(mg[k] >> (sh - 6'd30));
					else nm_q[k] <= 30'(mg[k] << (6'd30 - sh));
				end
				degen_q <= (mmax == '0);
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			tfn_pkg::BS_SQRT: begin
				// radicand is built first, while the count is zero, then 32 root steps
				if (cnt_q == 6'd0) begin
					sq = 60'(nm_q[0]) * 60'(nm_q[0]);
					s_q <= 64'(sq) + 64'(60'(nm_q[1]) * 60'(nm_q[1]))
						+ 64'(60'(nm_q[2]) * 60'(nm_q[2]));
					cnt_q <= 6'd1;
					rem_q <= '0;
					root_q <= '0;
				end else begin
					s_q <= {s_q[61:0], 2'b00};
					if (!sq_trial[65]) begin
						rem_q <= sq_trial[63:0];
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= sq_rem[63:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						// half the final root is the old root without its top bit
						cnt_q <= '0;
						comp_q <= '0;
						num_q <= {1'b0, nm_q[0], 14'd0} + 45'(root_q[30:0]);
						drem_q <= '0;
						quo_q <= '0;
					end
				end
			end
			tfn_pkg::BS_DIV: begin
				num_q <= {num_q[43:0], 1'b0};
				if (!dv_trial[46]) drem_q <= dv_trial[45:0];
				else drem_q <= {drem_q[44:0], num_q[44]};
				quo_q <= quo_nx;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd44) begin
					if (quo_nx[30:0] >= 31'(tfn_pkg::NORM_ONE) || quo_nx[31])
						res_q[comp_q] <= neg_q[comp_q] ? -tfn_pkg::NORM_ONE : tfn_pkg::NORM_ONE;
					else
						res_q[comp_q] <= neg_q[comp_q] ? -NW'(quo_nx) : NW'(quo_nx);
					comp_q <= comp_q + 2'd1;
					cnt_q <= '0;
					num_q <= {1'b0, nm_q[(comp_q == 2'd0) ? 1 : 2], 14'd0}
						+ 45'(root_q[31:1]);
					drem_q <= '0;
					quo_q <= '0;
				end
			end
			tfn_pkg::BS_OUT: begin
				if (!ovalid_q || !out_stall) begin
					obuf_q.result_kind <= cmd_q.face;
					obuf_q.normal_x <= res_q[0];
					obuf_q.normal_y <= res_q[1];
					obuf_q.normal_z <= res_q[2];
					obuf_q.degenerate <= cmd_q.face & degen_q;
					obuf_q.extent_x <= cmd_q.ext_x;
					obuf_q.extent_y <= cmd_q.ext_y;
					obuf_q.extent_z <= cmd_q.ext_z;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_beat = obuf_q;
endmodule
`default_nettype wire

FILE: bench/tb_triangle_face_normal_engine.sv
// testbench for the triangle face normal engine: random loads and faces checked against a predictor
`default_nettype none
module tb_triangle_face_normal_engine;

	localparam int STALL_LIMIT = 6000;   // cycles with no beat accepted on either side
	localparam int HOLD_CYCLES = 700;    // long receiver hold-off
	localparam int RANDOM_BEATS = 1920;
	localparam int IN_W = $bits(tfn_pkg::in_beat_t);

	// expected-normal store and vertex table predictor
	class normal_scoreboard;
		longint vtab [4096][3];
		bit written [4096];
		int written_q [$];
		longint unsigned ext [3];
		tfn_pkg::out_beat_t pending_q [$];
		int errors;
		int loads, faces, degen_faces;

		function new();
			errors = 0;
			loads = 0;
			faces = 0;
			degen_faces = 0;
			ext = '{0, 0, 0};
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		function longint unsigned isqrt(longint unsigned s);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'h4000_0000_0000_0000;
			while (bitv > s)
				bitv >>= 2;
			while (bitv != 0) begin
				if (s >= res + bitv) begin
					s -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function tfn_pkg::out_beat_t face_normal(tfn_pkg::in_beat_t b);
			tfn_pkg::out_beat_t r;
			longint va [3], vb [3], vc [3], e1 [3], e2 [3], cr [3];
			longint unsigned mg [3];
			longint unsigned m, s, len, n;
			logic [15:0] comp;
			int bl;
			r = '0;
			r.result_kind = b.mode;
			for (int k = 0; k < 3; k++) begin
				va[k] = vtab[b.corner_one][k];
				vb[k] = vtab[b.corner_two][k];
				vc[k] = vtab[b.corner_three][k];
				e1[k] = va[k] - vb[k];
				e2[k] = va[k] - vc[k];
			end
			// products stay far below 2^64 at 24-bit coordinates, no halving step
			cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
			cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
			cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
			m = 0;
			for (int k = 0; k < 3; k++) begin
				mg[k] = mag(cr[k]);
				if (mg[k] > m)
					m = mg[k];
			end
			if (m == 0) begin
				r.degenerate = 1'b1;
				degen_faces++;
			end else begin
				bl = 0;
				while (bl < 64 && (m >> bl) != 0)
					bl++;
				s = 0;
				for (int k = 0; k < 3; k++) begin
					if (bl > 30)
						mg[k] >>= (bl - 30);
					else
						mg[k] <<= (30 - bl);
					s += mg[k] * mg[k];
				end
				len = isqrt(s);
				for (int k = 0; k < 3; k++) begin
					n = (mg[k] * 16384 + len / 2) / len;
					if (n > 16384)
						n = 16384;
					comp = n[15:0];
					if (cr[k] < 0)
						comp = -comp;
					if (k == 0) r.normal_x = comp;
					else if (k == 1) r.normal_y = comp;
					else r.normal_z = comp;
				end
			end
			return r;
		endfunction

		function void note_input(tfn_pkg::in_beat_t b);
			tfn_pkg::out_beat_t r;
			longint c [3];
			if (b.mode == tfn_pkg::MODE_LOAD) begin
				r = '0;
				c[0] = longint'(b.coord_x);
				c[1] = longint'(b.coord_y);
				c[2] = longint'(b.coord_z);
				for (int k = 0; k < 3; k++) begin
					vtab[b.vertex_slot][k] = c[k];
					if (mag(c[k]) > ext[k])
						ext[k] = mag(c[k]);
				end
				if (!written[b.vertex_slot]) begin
					written[b.vertex_slot] = 1'b1;
					written_q.insert(written_q.size(), int'(b.vertex_slot));
				end
				loads++;
			end else begin
				r = face_normal(b);
				faces++;
			end
			r.result_kind = b.mode;
			r.extent_x = ext[0][23:0];
			r.extent_y = ext[1][23:0];
			r.extent_z = ext[2][23:0];
			pending_q.insert(pending_q.size(), r);
		endfunction

		task check_result(tfn_pkg::out_beat_t got);
			tfn_pkg::out_beat_t want;
			if (pending_q.size() == 0) begin
				report("unexpected beat", longint'(got.result_kind), -1);
			end else begin
				want = pending_q.pop_front();
				if (got.result_kind !== want.result_kind)
					report("result_kind", longint'(got.result_kind),
						longint'(want.result_kind));
				if (got.normal_x !== want.normal_x)
					report("normal_x", longint'(got.normal_x), longint'(want.normal_x));
				if (got.normal_y !== want.normal_y)
					report("normal_y", longint'(got.normal_y), longint'(want.normal_y));
				if (got.normal_z !== want.normal_z)
					report("normal_z", longint'(got.normal_z), longint'(want.normal_z));
				if (got.degenerate !== want.degenerate)
					report("degenerate", longint'(got.degenerate),
						longint'(want.degenerate));
				if (got.extent_x !== want.extent_x)
					report("extent_x", longint'(got.extent_x), longint'(want.extent_x));
				if (got.extent_y !== want.extent_y)
					report("extent_y", longint'(got.extent_y), longint'(want.extent_y));
				if (got.extent_z !== want.extent_z)
					report("extent_z", longint'(got.extent_z), longint'(want.extent_z));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tfn_pkg::in_beat_t in_beat;
	logic out_valid;
	logic out_stall;
	tfn_pkg::out_beat_t out_beat;

	normal_scoreboard sb;
	int idle_pct;       // sender gap odds, percent
	int stall_pct;      // receiver stall odds, percent
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	triangle_face_normal_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or a long counted hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// both sides sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_beat);
			if (out_valid && !out_stall)
				sb.check_result(out_beat);
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("triangle_face_normal_engine test failed");
			$finish;
		end
	end

	function automatic tfn_pkg::in_beat_t noise_beat();
		tfn_pkg::in_beat_t b;
		b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		return b;
	endfunction

	// offer one beat with optional leading gaps, hold it until taken
	task send_beat(tfn_pkg::in_beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			in_beat = noise_beat();
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_beat = b;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task load_vertex(int slot, int x, int y, int z);
		tfn_pkg::in_beat_t b;
		b = noise_beat();
		b.mode = tfn_pkg::MODE_LOAD;
		b.vertex_slot = 12'(slot);
		b.coord_x = 24'(x);
		b.coord_y = 24'(y);
		b.coord_z = 24'(z);
		send_beat(b);
	endtask

	task face(int c1, int c2, int c3);
		tfn_pkg::in_beat_t b;
		b = noise_beat();
		b.mode = tfn_pkg::MODE_FACE;
		b.corner_one = 12'(c1);
		b.corner_two = 12'(c2);
		b.corner_three = 12'(c3);
		send_beat(b);
	endtask

	function automatic int rand_coord();
		if ($urandom_range(1))
			return $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
		return $signed($urandom_range(16384)) - 8192;
	endfunction

	function automatic int pick_slot();
		return sb.written_q[$urandom_range(sb.written_q.size() - 1)];
	endfunction

	task wait_drained();
		in_valid = 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int c1;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: coordinate extremes, table ends, axis-aligned and flat faces
		load_vertex(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		load_vertex(4095, -8388608, -8388608, -8388608);
		load_vertex(1, 0, 0, 0);
		load_vertex(2, 4096, 0, 0);
		load_vertex(3, 0, 4096, 0);
		load_vertex(4, 0, 0, 4096);
		load_vertex(2048, 8192, 8192, 8192);
		load_vertex(5, -1, 24'sh7FFFFF, -8388608);
		face(1, 2, 3);
		face(1, 3, 2);
		face(1, 2, 4);
		face(1, 3, 4);
		face(2, 3, 4);
		face(5, 5, 5);              // all corners equal
		face(1, 2, 2048);           // origin, axis point and diagonal point
		face(1, 2048, 0);           // collinear, far end
		face(0, 4095, 5);
		face(4095, 0, 2);
		face(5, 0, 4095);
		face(2048, 4095, 3);
		load_vertex(2, -4096, 1, -1);
		face(1, 2, 3);

		// pressure: receiver holds off while loads keep coming, then a full pause
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			load_vertex($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
		wait_drained();

		// random: loads, and faces over written slots, in phases of sender idling and receiver stalls
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			case ((i / 120) % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 68; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 68; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			if ($urandom_range(99) < 55) begin
				if ($urandom_range(99) < 70)
					load_vertex($urandom_range(4095), rand_coord(), rand_coord(),
						rand_coord());
				else
					load_vertex($urandom_range(31), rand_coord(), rand_coord(),
						rand_coord());
			end else if ($urandom_range(99) < 8) begin
				c1 = pick_slot();
				face(c1, c1, pick_slot());
			end else begin
				face(pick_slot(), pick_slot(), pick_slot());
			end
		end

		wait_drained();
		stall_pct = 0;
		repeat (250) @(negedge clk);
		sb.errors += sb.pending_q.size();
		$display("covered %0d vertex loads and %0d face normals (%0d flat)",
			sb.loads, sb.faces, sb.degen_faces);
		$display("idling phases, a long output hold-off and %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("triangle_face_normal_engine test passed");
		else
			$display("triangle_face_normal_engine test failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hdl/tfn_pkg.sv
hdl/tfn_front.sv
hdl/tfn_queue.sv
hdl/tfn_back.sv
hdl/triangle_face_normal_engine.sv
bench/tb_triangle_face_normal_engine.sv
